### design/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and codes for the streaming UTF-8 decoder: byte classes,
// result status codes and the classified byte carried between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NULL  = 3'd1;
  localparam logic [2:0] ST_LEAD  = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_CONT  = 3'd4;
  localparam logic [2:0] ST_VALUE = 3'd5;

  // Byte classes when the byte stands in lead position
  localparam logic [2:0] CLS_NULL    = 3'd0;
  localparam logic [2:0] CLS_ASCII   = 3'd1;
  localparam logic [2:0] CLS_LEAD2   = 3'd2;
  localparam logic [2:0] CLS_LEAD3   = 3'd3;
  localparam logic [2:0] CLS_LEAD4   = 3'd4;
  localparam logic [2:0] CLS_BADLEAD = 3'd5;

  // Classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] lead_class;
    logic       is_cont;
    logic       last;
  } item_t;

endpackage

`default_nettype wire

### design/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front
// Input side: takes raw bytes, classifies each one as a lead byte and as a
// continuation byte, and pushes the classified byte into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_front
  import u8d_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output item_t           q_item
);

  logic [2:0] lead_class;

  // Classify the byte in lead position
  always_comb begin
    if (data_byte == 8'h00) begin
      lead_class = CLS_NULL;
    end else if (!data_byte[7]) begin
      lead_class = CLS_ASCII;
    end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
      lead_class = CLS_LEAD2;
    end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
      lead_class = CLS_LEAD3;
    end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
      lead_class = CLS_LEAD4;
    end else begin
      lead_class = CLS_BADLEAD;
    end
  end

  // Push a transaction when a byte is offered and the queue has room
  assign in_ready          = !q_full;
  assign q_push            = in_valid && !q_full;
  assign q_item.data       = data_byte;
  assign q_item.lead_class = lead_class;
  assign q_item.is_cont    = (data_byte[7:6] == 2'b10);
  assign q_item.last       = last_byte;

endmodule

`default_nettype wire

### design/u8d_queue.sv
// ----------------------------------------------------------------------------
// u8d_queue
// Two-entry queue of classified bytes between the front and the back, so
// that either side can stall without stopping the other at once.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_queue
  import u8d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output item_t      pop_item
);

  item_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_item  = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue occupancy out of range");

  a_no_bad_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

endmodule

`default_nettype wire

### design/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back
// Decode side: pops classified bytes, tracks the sequence in progress,
// validates completed scalars and loads results into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_back
  import u8d_pkg::*;
#(
  parameter int unsigned MAX_STRING_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_not_empty,
  input  wire item_t       q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [20:0]      code_point,
  output logic [2:0]       status,
  output logic [16:0]      char_count,
  output logic [15:0]      char_offset,
  output logic             string_end
);

  localparam logic [16:0] COUNT_LIMIT =
    (MAX_STRING_BYTES < 32'h1FFFF) ? 17'(MAX_STRING_BYTES) : 17'h1FFFF;

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [2:0]  sequence_length, sequence_length_next;
  logic [20:0] accumulator, accumulator_next;
  logic [16:0] chars_seen, chars_seen_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] start_position, start_position_next;
  logic        dropping, dropping_next;

  logic        emit;
  logic [2:0]  res_status;
  logic [20:0] res_cp;
  logic [20:0] acc_shift;
  logic        scalar_ok;

  // Pop when a byte waits and the output register is free
  assign q_pop = q_not_empty && (!out_valid || out_ready);

  // Shift a continuation byte into the partial scalar
  assign acc_shift = {accumulator[14:0], q_item.data[5:0]};

  // Check a completed scalar against overlong, surrogate and range limits
  always_comb begin
    scalar_ok = 1'b1;
    if (sequence_length == 3'd3 && acc_shift < 21'h800) begin
      scalar_ok = 1'b0;
    end
    if (sequence_length == 3'd4 && acc_shift < 21'h10000) begin
      scalar_ok = 1'b0;
    end
    if (acc_shift >= 21'hD800 && acc_shift <= 21'hDFFF) begin
      scalar_ok = 1'b0;
    end
    if (acc_shift > 21'h10FFFF) begin
      scalar_ok = 1'b0;
    end
  end

  // Step the decoder state for one popped byte
  always_comb begin
    bytes_pending_next   = bytes_pending;
    sequence_length_next = sequence_length;
    accumulator_next     = accumulator;
    chars_seen_next      = chars_seen;
    byte_position_next   = byte_position;
    start_position_next  = start_position;
    dropping_next        = dropping;
    emit                 = 1'b0;
    res_status           = ST_OK;
    res_cp               = 21'd0;

    if (dropping) begin
      // drop silently until the last byte
    end else if (bytes_pending == 2'd0) begin
      start_position_next = byte_position;
      unique case (q_item.lead_class)
        CLS_NULL: begin
          emit       = 1'b1;
          res_status = ST_NULL;
        end
        CLS_ASCII: begin
          emit   = 1'b1;
          res_cp = {13'd0, q_item.data};
        end
        CLS_LEAD2: begin
          bytes_pending_next   = 2'd1;
          sequence_length_next = 3'd2;
          accumulator_next     = {16'd0, q_item.data[4:0]};
        end
        CLS_LEAD3: begin
          bytes_pending_next   = 2'd2;
          sequence_length_next = 3'd3;
          accumulator_next     = {17'd0, q_item.data[3:0]};
        end
        CLS_LEAD4: begin
          bytes_pending_next   = 2'd3;
          sequence_length_next = 3'd4;
          accumulator_next     = {18'd0, q_item.data[2:0]};
        end
        default: begin
          emit       = 1'b1;
          res_status = ST_LEAD;
        end
      endcase
    end else if (!q_item.is_cont) begin
      emit       = 1'b1;
      res_status = ST_CONT;
    end else begin
      accumulator_next   = acc_shift;
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending_next == 2'd0) begin
        emit = 1'b1;
        if (scalar_ok) begin
          res_cp = acc_shift;
        end else begin
          res_status = ST_VALUE;
        end
      end
    end

    // Report a string that ends inside a sequence
    if (!dropping && !emit && q_item.last && bytes_pending_next != 2'd0) begin
      emit       = 1'b1;
      res_status = ST_TRUNC;
    end

    if (emit) begin
      if (res_status == ST_OK) begin
        if (chars_seen < COUNT_LIMIT) begin
          chars_seen_next = chars_seen + 17'd1;
        end
      end else begin
        res_cp        = 21'd0;
        dropping_next = 1'b1;
      end
      bytes_pending_next   = 2'd0;
      sequence_length_next = 3'd0;
      accumulator_next     = 21'd0;
    end
  end

  // Hold decoder state; clear it after the last byte of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= 2'd0;
      sequence_length <= 3'd0;
      accumulator     <= 21'd0;
      chars_seen      <= 17'd0;
      byte_position   <= 16'd0;
      start_position  <= 16'd0;
      dropping        <= 1'b0;
    end else if (q_pop) begin
      if (q_item.last) begin
        bytes_pending   <= 2'd0;
        sequence_length <= 3'd0;
        accumulator     <= 21'd0;
        chars_seen      <= 17'd0;
        byte_position   <= 16'd0;
        start_position  <= 16'd0;
        dropping        <= 1'b0;
      end else begin
        bytes_pending   <= bytes_pending_next;
        sequence_length <= sequence_length_next;
        accumulator     <= accumulator_next;
        chars_seen      <= chars_seen_next;
        byte_position   <= byte_position + 16'd1;
        start_position  <= start_position_next;
        dropping        <= dropping_next;
      end
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      code_point  <= res_cp;
      status      <= res_status;
      char_count  <= chars_seen_next;
      char_offset <= start_position_next;
      string_end  <= q_item.last;
    end
  end

  a_drop_idle: assert property (@(posedge clk) disable iff (rst)
    dropping |-> bytes_pending == 2'd0)
    else $error("pending bytes while dropping");

  a_len_covers_pending: assert property (@(posedge clk) disable iff (rst)
    bytes_pending != 2'd0 |-> sequence_length > {1'b0, bytes_pending})
    else $error("sequence length below pending count");

  a_error_no_cp: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> code_point == 21'd0)
    else $error("error result carries a code point");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> code_point != 21'd0)
    else $error("good result with null code point");

endmodule

`default_nettype wire

### design/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Strict streaming UTF-8 decoder, one byte per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one string byte per transaction, with
// last_byte set on the final byte of the string.
// Output channel (out_valid/out_ready): one transaction per completed scalar
// or per error, carrying code point, status, running character count, byte
// offset of the sequence start and string_end.
// After an error, the rest of the string is dropped with no output; the last
// byte returns all decoder state to the start-of-string condition.
// Throughput: one byte per cycle unless the receiver stalls, set by the state
// update in the decode stage. A byte taken is written into the queue, then
// popped by the decode stage, and its result is loaded into the output
// register.
// When the receiver stalls, the output register holds its result, the queue
// fills, and in_ready drops after two more bytes. Reset (rst, synchronous)
// empties the queue and output register and starts a fresh string.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_top
  import u8d_pkg::*;
#(
  parameter int unsigned MAX_STRING_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [20:0]      code_point,
  output logic [2:0]       status,
  output logic [16:0]      char_count,
  output logic [15:0]      char_offset,
  output logic             string_end
);

  logic  q_full;
  logic  q_push;
  item_t q_push_item;
  logic  q_pop;
  logic  q_not_empty;
  item_t q_pop_item;

  u8d_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  u8d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_pop_item)
  );

  u8d_back #(
    .MAX_STRING_BYTES (MAX_STRING_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_item      (q_pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .status      (status),
    .char_count  (char_count),
    .char_offset (char_offset),
    .string_end  (string_end)
  );

endmodule

`default_nettype wire

### verif/utf8_stream_decoder_checker.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_checker
// Watches both channels of the streaming UTF-8 decoder. It decodes every
// accepted byte with its own copy of the decoder state, queues the scalar or
// error result that byte should cause, and compares each result transaction
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_checker
  import u8d_pkg::*;
#(
  parameter int unsigned MAX_STRING_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [20:0] code_point,
  input  logic [2:0]  status,
  input  logic [16:0] char_count,
  input  logic [15:0] char_offset,
  input  logic        string_end,
  output int          fails,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_CAP =
    (MAX_STRING_BYTES < 32'h1FFFF) ? MAX_STRING_BYTES : 32'h1FFFF;

  typedef struct {
    logic [20:0] scalar;
    logic [2:0]  code;
    logic [16:0] count;
    logic [15:0] offset;
    logic        at_end;
  } scalar_result_t;

  scalar_result_t scalars_due[$];

  // Decoder state as seen from the byte stream
  logic [1:0]  cont_due;
  logic [2:0]  seq_len;
  logic [20:0] partial;
  logic [16:0] good_chars;
  logic [15:0] byte_pos;
  logic [15:0] lead_pos;
  logic        dropping;

  initial begin
    fails = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    fails++;
  endtask

  task automatic restart_string();
    cont_due   = '0;
    seq_len    = '0;
    partial    = '0;
    good_chars = '0;
    byte_pos   = '0;
    lead_pos   = '0;
    dropping   = 1'b0;
  endtask

  // Advance the decoder by one byte and queue the result it causes, if any
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic           emit;
    logic [2:0]     code;
    logic [20:0]    scalar;
    scalar_result_t res;
    emit = 1'b0;
    code = ST_OK;
    scalar = '0;

    // Swallow the rest of a string after an error
    if (dropping) begin
      if (last) restart_string();
      else byte_pos = byte_pos + 16'd1;
      return;
    end

    if (cont_due == 2'd0) begin
      lead_pos = byte_pos;
      if (b == 8'h00) begin
        emit = 1'b1;
        code = ST_NULL;
      end else if (b < 8'h80) begin
        emit = 1'b1;
        scalar = {13'd0, b};
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        cont_due = 2'd1;
        seq_len  = 3'd2;
        partial  = {16'd0, b[4:0]};
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        cont_due = 2'd2;
        seq_len  = 3'd3;
        partial  = {17'd0, b[3:0]};
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        cont_due = 2'd3;
        seq_len  = 3'd4;
        partial  = {18'd0, b[2:0]};
      end else begin
        emit = 1'b1;
        code = ST_LEAD;
      end
    end else if (b[7:6] != 2'b10) begin
      emit = 1'b1;
      code = ST_CONT;
    end else begin
      partial  = {partial[14:0], b[5:0]};
      cont_due = cont_due - 2'd1;
      if (cont_due == 2'd0) begin
        emit = 1'b1;
        // Reject overlong forms, surrogates and values past the last plane
        if ((seq_len == 3'd3 && partial < 21'h800) ||
            (seq_len == 3'd4 && partial < 21'h10000) ||
            (partial >= 21'hD800 && partial <= 21'hDFFF) ||
            partial > 21'h10FFFF)
          code = ST_VALUE;
        else
          scalar = partial;
      end
    end

    // String ends inside a sequence
    if (!emit && last && cont_due != 2'd0) begin
      emit = 1'b1;
      code = ST_TRUNC;
    end

    if (emit) begin
      if (code == ST_OK) begin
        if (good_chars < COUNT_CAP) good_chars = good_chars + 17'd1;
      end else begin
        scalar = '0;
        dropping = 1'b1;
      end
      cont_due = '0;
      seq_len  = '0;
      partial  = '0;
      res.scalar = scalar;
      res.code   = code;
      res.count  = good_chars;
      res.offset = lead_pos;
      res.at_end = last;
      scalars_due.push_back(res);
    end

    if (last) restart_string();
    else byte_pos = byte_pos + 16'd1;
  endtask

  // Compare results first, then decode the byte taken at the same edge
  always @(posedge clk) begin
    scalar_result_t want;
    if (rst) begin
      restart_string();
      scalars_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (scalars_due.size() == 0) begin
          report_mismatch("result transaction with none pending", status, 0);
        end else begin
          want = scalars_due.pop_front();
          if (code_point !== want.scalar)
            report_mismatch("code_point", code_point, want.scalar);
          if (status !== want.code)
            report_mismatch("status", status, want.code);
          if (char_count !== want.count)
            report_mismatch("char_count", char_count, want.count);
          if (char_offset !== want.offset)
            report_mismatch("char_offset", char_offset, want.offset);
          if (string_end !== want.at_end)
            report_mismatch("string_end", string_end, want.at_end);
        end
      end
      if (in_valid && in_ready) decode_byte(data_byte, last_byte);
    end
    outstanding <= scalars_due.size();
  end

endmodule

### verif/utf8_stream_decoder_top_test.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_test
// Drives strings into the streaming UTF-8 decoder: a short directed set of
// valid extremes and every error kind, then random strings that are mostly
// well formed with some broken sequences and raw noise, across several
// idle and stall mixes, a long receiver hold-off, and one longer ASCII
// string at the end.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_test;
  import u8d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BYTES    = 65536;
  localparam int          CYCLE_LIMIT  = 50000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PHASE_ITEMS  = 300;
  localparam int          LONG_BYTES   = 100;
  localparam int          DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [20:0] code_point;
  logic [2:0]  status;
  logic [16:0] char_count;
  logic [15:0] char_offset;
  logic        string_end;

  int  fails;
  int  outstanding;
  int  cycle_count = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  int  items_sent = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int  hold_left = 0;
  logic [7:0] str_bytes[$];

  always #2ns clk = ~clk;

  utf8_stream_decoder_top #(
    .MAX_STRING_BYTES(MAX_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .status     (status),
    .char_count (char_count),
    .char_offset(char_offset),
    .string_end (string_end)
  );

  utf8_stream_decoder_checker #(
    .MAX_STRING_BYTES(MAX_BYTES)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .status     (status),
    .char_count (char_count),
    .char_offset(char_offset),
    .string_end (string_end),
    .fails      (fails),
    .outstanding(outstanding)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one byte, idling first at random, and wait for its transaction
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++)
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
    str_bytes.delete();
  endtask

  // Encode raw bits into a sequence of the given length, overlong or not
  task automatic append_scalar(input int len, input logic [20:0] v);
    case (len)
      1: str_bytes.push_back(v[7:0]);
      2: begin
        str_bytes.push_back({3'b110, v[10:6]});
        str_bytes.push_back({2'b10, v[5:0]});
      end
      3: begin
        str_bytes.push_back({4'b1110, v[15:12]});
        str_bytes.push_back({2'b10, v[11:6]});
        str_bytes.push_back({2'b10, v[5:0]});
      end
      default: begin
        str_bytes.push_back({5'b11110, v[20:18]});
        str_bytes.push_back({2'b10, v[17:12]});
        str_bytes.push_back({2'b10, v[11:6]});
        str_bytes.push_back({2'b10, v[5:0]});
      end
    endcase
  endtask

  task automatic append_good_scalar(output int len);
    logic [20:0] v;
    len = $urandom_range(1, 4);
    case (len)
      1: v = 21'($urandom_range(1, 'h7F));
      2: v = 21'($urandom_range('h80, 'h7FF));
      3: begin
        v = 21'($urandom_range('h800, 'hFFFF));
        while (v >= 'hD800 && v <= 'hDFFF) v = 21'($urandom_range('h800, 'hFFFF));
      end
      default: v = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    append_scalar(len, v);
  endtask

  // Build a random string: mostly valid scalars, some broken sequences
  task automatic build_string();
    int nchars;
    int len;
    int cut;
    nchars = $urandom_range(1, 6);
    if ($urandom_range(99) < 8) begin
      // raw noise
      for (int i = 0; i < nchars; i++) str_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    for (int i = 0; i < nchars; i++) begin
      if ($urandom_range(99) < 85) begin
        append_good_scalar(len);
      end else begin
        case ($urandom_range(0, 6))
          0: str_bytes.push_back(8'h00);
          1: begin
            if ($urandom_range(1)) str_bytes.push_back(8'($urandom_range('h80, 'hC1)));
            else str_bytes.push_back(8'($urandom_range('hF5, 'hFF)));
          end
          2: begin
            // drop the tail of a multi-byte sequence
            len = 1;
            while (len == 1) append_good_scalar(len);
            if (len == 1) cut = 0;
            cut = $urandom_range(1, len - 1);
            repeat (cut) void'(str_bytes.pop_back());
          end
          3: append_scalar(3, 21'($urandom_range('hD800, 'hDFFF)));
          4: begin
            len = $urandom_range(2, 4);
            if (len == 2) append_scalar(2, 21'($urandom_range(0, 'h7F)));
            else if (len == 3) append_scalar(3, 21'($urandom_range(0, 'h7FF)));
            else append_scalar(4, 21'($urandom_range(0, 'hFFFF)));
          end
          5: append_scalar(4, 21'($urandom_range('h110000, 'h13FFFF)));
          default: str_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    phase_idle  = '{0, 78, 0, 7};
    phase_stall = '{0, 0, 78, 7};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: valid extremes, then each error kind
    str_bytes = '{8'h01, 8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                  8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
    str_bytes = '{8'hED, 8'hA0, 8'h80};   // surrogate on the last byte
    send_string();
    str_bytes = '{8'hFF, 8'h41, 8'h00};   // bad lead, then dropped bytes
    send_string();
    str_bytes = '{8'hC2, 8'h41};          // bad continuation on the last byte
    send_string();
    str_bytes = '{8'hE0, 8'hA0};          // truncated at the end
    send_string();
    str_bytes = '{8'h00};                 // null as the last byte
    send_string();
    str_bytes = '{8'hE0, 8'h80, 8'h80};   // overlong three-byte form
    send_string();

    // Random strings under each idle and stall mix
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct <= phase_stall[p];
      if (p == 0) hold_go <= ~hold_go;
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        build_string();
        send_string();
      end
    end

    // One longer ASCII string
    idle_pct = 0;
    stall_pct <= 0;
    for (int i = 0; i < LONG_BYTES; i++)
      send_byte(8'($urandom_range(1, 'h7F)), i == LONG_BYTES - 1);
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
